FILE: design/lvps_pkg.sv
// lvps_pkg: shared types and constants of the latching valve pulse sequencer
`default_nettype none

package lvps_pkg;

    localparam int unsigned CoilWidth  = 24;
    localparam int unsigned HalfWidth  = 16;
    localparam int unsigned CmdWidth   = 2;
    localparam int unsigned CfgAddrWidth = 2;
    localparam int unsigned CfgDataWidth = 24;

    // command codes
    localparam logic [CmdWidth-1:0] CMD_TICK  = 2'd0;
    localparam logic [CmdWidth-1:0] CMD_OPEN  = 2'd1;
    localparam logic [CmdWidth-1:0] CMD_CLOSE = 2'd2;

    // configuration register indexes
    localparam logic [CfgAddrWidth-1:0] REG_COIL_PULSE = 2'd0;
    localparam logic [CfgAddrWidth-1:0] REG_TIMEOUT    = 2'd1;
    localparam logic [CfgAddrWidth-1:0] REG_HALF_PER   = 2'd2;
    localparam logic [CfgAddrWidth-1:0] REG_RECHARGE   = 2'd3;

    typedef struct packed {
        logic [CoilWidth-1:0] coil_pulse_ticks;
        logic [CoilWidth-1:0] discharge_timeout_ticks;
        logic [HalfWidth-1:0] half_period_ticks;
        logic [HalfWidth-1:0] recharge_toggles;
    } cfg_t;

    typedef struct packed {
        logic timeout_error;
        logic done_res;
        logic busy_res;
        logic reference_on;
        logic boost_switch;
        logic close_coil;
        logic open_coil;
    } result_t;

endpackage

`default_nettype wire

FILE: design/lvps_core.sv
// lvps_core: sequence state and one-tick next-state logic
`default_nettype none

module lvps_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                advance,
    input  wire logic [lvps_pkg::CmdWidth-1:0]       command,
    input  wire logic                                comparator_high,
    input  wire lvps_pkg::cfg_t                      cfg,
    output lvps_pkg::result_t                        result
);

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_PRE      = 3'd1,
        PH_WAIT     = 3'd2,
        PH_CHARGE   = 3'd3,
        PH_DRIVE    = 3'd4,
        PH_RECHARGE = 3'd5
    } phase_t;

    phase_t                            phase_reg, phase_next;
    logic                              target_is_open_reg, target_is_open_next;
    logic [lvps_pkg::CoilWidth-1:0]    phase_counter_reg, phase_counter_next;
    logic [lvps_pkg::HalfWidth-1:0]    half_period_counter_reg, half_period_counter_next;
    logic [lvps_pkg::HalfWidth-1:0]    toggles_left_reg, toggles_left_next;
    logic                              boost_level_reg, boost_level_next;
    logic                              timed_out_reg, timed_out_next;

    logic [lvps_pkg::CoilWidth-1:0]    coil_len;
    logic [lvps_pkg::HalfWidth-1:0]    half_len;
    logic [lvps_pkg::HalfWidth-1:0]    toggles_dec;
    logic                              coil_end;
    logic                              half_end;
    logic                              done;
    logic                              opp_drive;
    logic                              tgt_drive;
    logic                              busy;

    assign coil_len = (cfg.coil_pulse_ticks == '0) ?
        lvps_pkg::CoilWidth'(1) : cfg.coil_pulse_ticks;
    assign half_len = (cfg.half_period_ticks == '0) ?
        lvps_pkg::HalfWidth'(1) : cfg.half_period_ticks;
    assign coil_end    = (phase_counter_reg <= lvps_pkg::CoilWidth'(1));
    assign half_end    = (half_period_counter_reg <= lvps_pkg::HalfWidth'(1));
    assign toggles_dec = toggles_left_reg - lvps_pkg::HalfWidth'(1);

    always_comb
    begin
        phase_next               = phase_reg;
        target_is_open_next      = target_is_open_reg;
        phase_counter_next       = phase_counter_reg;
        half_period_counter_next = half_period_counter_reg;
        toggles_left_next        = toggles_left_reg;
        boost_level_next         = boost_level_reg;
        timed_out_next           = timed_out_reg;
        done                     = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (command == lvps_pkg::CMD_OPEN || command == lvps_pkg::CMD_CLOSE)
                begin
                    target_is_open_next = (command == lvps_pkg::CMD_OPEN);
                    timed_out_next      = 1'b0;
                    phase_counter_next  = coil_len;
                    phase_next          = PH_PRE;
                end
            end
            PH_PRE:
            begin
                if (coil_end)
                begin
                    phase_counter_next = cfg.discharge_timeout_ticks;
                    phase_next         = PH_WAIT;
                end
                else
                begin
                    phase_counter_next = phase_counter_reg - lvps_pkg::CoilWidth'(1);
                end
            end
            PH_WAIT:
            begin
                // error is flagged whenever the budget is spent, even if the comparator fell
                if (!comparator_high || phase_counter_reg == '0)
                begin
                    timed_out_next           = (phase_counter_reg == '0);
                    boost_level_next         = ~boost_level_reg;
                    half_period_counter_next = half_len;
                    phase_next               = PH_CHARGE;
                end
                else
                begin
                    phase_counter_next = phase_counter_reg - lvps_pkg::CoilWidth'(1);
                end
            end
            PH_CHARGE:
            begin
                if (half_end)
                begin
                    half_period_counter_next = half_len;
                    if (comparator_high)
                    begin
                        boost_level_next   = 1'b0;
                        phase_counter_next = coil_len;
                        phase_next         = PH_DRIVE;
                    end
                    else
                    begin
                        boost_level_next = ~boost_level_reg;
                    end
                end
                else
                begin
                    half_period_counter_next = half_period_counter_reg -
                        lvps_pkg::HalfWidth'(1);
                end
            end
            PH_DRIVE:
            begin
                if (coil_end)
                begin
                    phase_counter_next       = '0;
                    boost_level_next         = ~boost_level_reg;
                    toggles_left_next        = cfg.recharge_toggles;
                    half_period_counter_next = half_len;
                    phase_next               = PH_RECHARGE;
                end
                else
                begin
                    phase_counter_next = phase_counter_reg - lvps_pkg::CoilWidth'(1);
                end
            end
            PH_RECHARGE:
            begin
                if (half_end)
                begin
                    half_period_counter_next = half_len;
                    // zero toggle count wraps to a full 16-bit run
                    toggles_left_next        = toggles_dec;
                    if (toggles_dec == '0)
                    begin
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        boost_level_next = ~boost_level_reg;
                    end
                end
                else
                begin
                    half_period_counter_next = half_period_counter_reg -
                        lvps_pkg::HalfWidth'(1);
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    assign busy      = (phase_next != PH_IDLE);
    assign opp_drive = (phase_next == PH_PRE);
    assign tgt_drive = (phase_next == PH_DRIVE);

    always_comb
    begin
        result.open_coil     = target_is_open_next ? tgt_drive : opp_drive;
        result.close_coil    = target_is_open_next ? opp_drive : tgt_drive;
        result.boost_switch  = boost_level_next;
        result.reference_on  = busy;
        result.busy_res      = busy;
        result.done_res      = done;
        result.timeout_error = done & timed_out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg               <= PH_IDLE;
            target_is_open_reg      <= 1'b0;
            phase_counter_reg       <= '0;
            half_period_counter_reg <= '0;
            toggles_left_reg        <= '0;
            boost_level_reg         <= 1'b0;
            timed_out_reg           <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg               <= phase_next;
            target_is_open_reg      <= target_is_open_next;
            phase_counter_reg       <= phase_counter_next;
            half_period_counter_reg <= half_period_counter_next;
            toggles_left_reg        <= toggles_left_next;
            boost_level_reg         <= boost_level_next;
            timed_out_reg           <= timed_out_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/latching_valve_pulse_sequencer.sv
// latching_valve_pulse_sequencer: top level with config registers and result register
//
//  channel  | direction | contents
//  s_*      | in        | one tick item: command, comparator_high
//  m_*      | out       | one result item per tick: coil, boost and status levels
//  cfg_*    | in        | register writes, no read-back
//
// a new tick item is accepted every cycle unless a stall on m_tready blocks intake
// the result lands in the output register in the cycle after acceptance
// s_tready stays high while the output register is empty or being drained
// reset clears the sequence to idle and loads the register defaults
// a stall on m_tready holds the result and stops intake, no item is lost
`default_nettype none

module latching_valve_pulse_sequencer (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    output      logic                                  s_tready,
    input  wire logic [7:0]                            s_tdata,  // command[1:0], comparator_high[2]
    output      logic                                  m_tvalid,
    input  wire logic                                  m_tready,
    output      logic [7:0]                            m_tdata,  // open_coil, close_coil,
                                                                 // boost_switch, reference_on,
                                                                 // busy_res, done_res,
                                                                 // timeout_error[6]
    input  wire logic                                  cfg_we,
    input  wire logic [lvps_pkg::CfgAddrWidth-1:0]     cfg_addr,
    input  wire logic [lvps_pkg::CfgDataWidth-1:0]     cfg_wdata
);

    lvps_pkg::cfg_t     cfg_reg;
    lvps_pkg::result_t  step_result;
    lvps_pkg::result_t  result_reg;
    logic               m_tvalid_reg;
    logic               accept;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coil_pulse_ticks        <= lvps_pkg::CoilWidth'(50);
            cfg_reg.discharge_timeout_ticks <= lvps_pkg::CoilWidth'(100000);
            cfg_reg.half_period_ticks       <= lvps_pkg::HalfWidth'(10);
            cfg_reg.recharge_toggles        <= lvps_pkg::HalfWidth'(10000);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                lvps_pkg::REG_COIL_PULSE: cfg_reg.coil_pulse_ticks <= cfg_wdata;
                lvps_pkg::REG_TIMEOUT:    cfg_reg.discharge_timeout_ticks <= cfg_wdata;
                lvps_pkg::REG_HALF_PER:
                    cfg_reg.half_period_ticks <= cfg_wdata[lvps_pkg::HalfWidth-1:0];
                lvps_pkg::REG_RECHARGE:
                    cfg_reg.recharge_toggles <= cfg_wdata[lvps_pkg::HalfWidth-1:0];
                default:
                begin
                end
            endcase
        end
    end

    lvps_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (accept),
        .command         (s_tdata[1:0]),
        .comparator_high (s_tdata[2]),
        .cfg             (cfg_reg),
        .result          (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= step_result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, result_reg.timeout_error, result_reg.done_res,
                       result_reg.busy_res, result_reg.reference_on,
                       result_reg.boost_switch, result_reg.close_coil,
                       result_reg.open_coil};

    // both coils never driven at once
    a_coils_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> !(result_reg.open_coil && result_reg.close_coil))
        else $error("open and close coils driven together");

    // error only reported on the done tick, and done ends the busy run
    a_error_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && result_reg.timeout_error |-> result_reg.done_res && !result_reg.busy_res)
        else $error("timeout error outside a done tick");

    // an accepted item always shows up at the output next cycle
    a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid_reg)
        else $error("accepted item produced no result");

    // coils only move while the reference is enabled
    a_coil_needs_ref: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && (result_reg.open_coil || result_reg.close_coil) |->
            result_reg.reference_on)
        else $error("coil driven with reference off");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// tb_top: self-checking testbench for the latching valve pulse sequencer
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [lvps_pkg::CmdWidth-1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned RANDOM_TICKS = 860;
    localparam int unsigned QUIET_LIMIT  = 1000;
    localparam int unsigned TAIL_CYCLES  = 10;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_OPPOSITE,
        SEQ_DISCHARGE,
        SEQ_CHARGE,
        SEQ_TARGET,
        SEQ_RECHARGE
    } seq_step_t;

    logic                                  clk       = 1'b0;
    logic                                  rst_n     = 1'b0;
    logic                                  s_tvalid  = 1'b0;
    logic                                  s_tready;
    logic [7:0]                            s_tdata   = 8'd0;  // command[1:0], comparator_high[2]
    logic                                  m_tvalid;
    logic                                  m_tready  = 1'b0;
    logic [7:0]                            m_tdata;  // open_coil, close_coil, boost_switch,
                                                     // reference_on, busy_res, done_res,
                                                     // timeout_error[6]
    logic                                  cfg_we    = 1'b0;
    logic [lvps_pkg::CfgAddrWidth-1:0]     cfg_addr  = '0;
    logic [lvps_pkg::CfgDataWidth-1:0]     cfg_wdata = '0;

    // predicted sequencer state
    lvps_pkg::cfg_t valve_cfg;
    seq_step_t   seq_phase     = SEQ_IDLE;
    logic        target_open   = 1'b0;
    logic [23:0] seq_count     = '0;
    logic [15:0] half_count    = '0;
    logic [15:0] toggles_left  = '0;
    logic        boost_level   = 1'b0;
    logic        seq_timed_out = 1'b0;

    lvps_pkg::result_t expected_levels[$];
    int unsigned ticks_sent     = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    logic        tx_idling      = 1'b1;
    logic        rx_idling      = 1'b1;

    latching_valve_pulse_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    initial
    begin
        valve_cfg.coil_pulse_ticks        = 24'd50;
        valve_cfg.discharge_timeout_ticks = 24'd100000;
        valve_cfg.half_period_ticks       = 16'd10;
        valve_cfg.recharge_toggles        = 16'd10000;
    end

    // one tick of the sequencer, returns the drive levels after the update
    function automatic lvps_pkg::result_t advance_valve(
        input logic [lvps_pkg::CmdWidth-1:0] cmd, input logic comp);
        lvps_pkg::result_t r;
        logic        finished;
        logic [23:0] coil_len;
        logic [15:0] half_len;
        finished = 1'b0;
        coil_len = (valve_cfg.coil_pulse_ticks == '0) ? 24'd1 : valve_cfg.coil_pulse_ticks;
        half_len = (valve_cfg.half_period_ticks == '0) ? 16'd1 : valve_cfg.half_period_ticks;
        case (seq_phase)
            SEQ_IDLE:
            begin
                if (cmd == lvps_pkg::CMD_OPEN || cmd == lvps_pkg::CMD_CLOSE)
                begin
                    target_open   = (cmd == lvps_pkg::CMD_OPEN);
                    seq_timed_out = 1'b0;
                    seq_count     = coil_len;
                    seq_phase     = SEQ_OPPOSITE;
                end
            end
            SEQ_OPPOSITE:
            begin
                if (seq_count <= 24'd1)
                begin
                    seq_count = valve_cfg.discharge_timeout_ticks;
                    seq_phase = SEQ_DISCHARGE;
                end
                else
                    seq_count = seq_count - 24'd1;
            end
            SEQ_DISCHARGE:
            begin
                // budget at zero flags even if the comparator fell on this tick
                if (!comp || seq_count == '0)
                begin
                    seq_timed_out = (seq_count == '0);
                    boost_level   = ~boost_level;
                    half_count    = half_len;
                    seq_phase     = SEQ_CHARGE;
                end
                else
                    seq_count = seq_count - 24'd1;
            end
            SEQ_CHARGE:
            begin
                if (half_count <= 16'd1)
                begin
                    half_count = half_len;
                    if (comp)
                    begin
                        boost_level = 1'b0;
                        seq_count   = coil_len;
                        seq_phase   = SEQ_TARGET;
                    end
                    else
                        boost_level = ~boost_level;
                end
                else
                    half_count = half_count - 16'd1;
            end
            SEQ_TARGET:
            begin
                if (seq_count <= 24'd1)
                begin
                    seq_count    = '0;
                    boost_level  = ~boost_level;
                    toggles_left = valve_cfg.recharge_toggles;
                    half_count   = half_len;
                    seq_phase    = SEQ_RECHARGE;
                end
                else
                    seq_count = seq_count - 24'd1;
            end
            SEQ_RECHARGE:
            begin
                if (half_count <= 16'd1)
                begin
                    half_count   = half_len;
                    // zero toggles wraps to a full 16-bit count
                    toggles_left = toggles_left - 16'd1;
                    if (toggles_left == '0)
                    begin
                        finished  = 1'b1;
                        seq_phase = SEQ_IDLE;
                    end
                    else
                        boost_level = ~boost_level;
                end
                else
                    half_count = half_count - 16'd1;
            end
            default:
                seq_phase = SEQ_IDLE;
        endcase
        r.open_coil     = target_open ? (seq_phase == SEQ_TARGET) : (seq_phase == SEQ_OPPOSITE);
        r.close_coil    = target_open ? (seq_phase == SEQ_OPPOSITE) : (seq_phase == SEQ_TARGET);
        r.boost_switch  = boost_level;
        r.reference_on  = (seq_phase != SEQ_IDLE);
        r.busy_res      = (seq_phase != SEQ_IDLE);
        r.done_res      = finished;
        r.timeout_error = finished & seq_timed_out;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            $display("%0t: %s expected %b got %b", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic send_item(input logic [lvps_pkg::CmdWidth-1:0] cmd, input logic comp);
        int unsigned gap;
        gap = tx_idling ? $urandom_range(0, 9) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, comp, cmd};
        do @(posedge clk); while (!s_tready);
        expected_levels.push_back(advance_valve(cmd, comp));
        ticks_sent++;
    endtask

    // stop sending and wait for every outstanding result
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_levels.size() != 0) @(posedge clk);
    endtask

    task automatic put_reg(input logic [lvps_pkg::CfgAddrWidth-1:0] idx,
                           input logic [lvps_pkg::CfgDataWidth-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    // only called with the sequencer idle
    task automatic set_config(input logic [23:0] coil, input logic [23:0] budget,
                              input logic [15:0] half, input logic [15:0] toggles);
        settle();
        put_reg(lvps_pkg::REG_COIL_PULSE, coil);
        put_reg(lvps_pkg::REG_TIMEOUT, budget);
        put_reg(lvps_pkg::REG_HALF_PER, {8'd0, half});
        put_reg(lvps_pkg::REG_RECHARGE, {8'd0, toggles});
        cfg_we <= 1'b0;
        valve_cfg.coil_pulse_ticks        = coil;
        valve_cfg.discharge_timeout_ticks = budget;
        valve_cfg.half_period_ticks       = half;
        valve_cfg.recharge_toggles        = toggles;
    endtask

    // one full open or close run; unless noisy, the comparator stays high for high_ticks of the
    // discharge wait and low for low_ticks of the charge step; noisy runs randomize command and comparator
    task automatic run_valve_cycle(input logic [lvps_pkg::CmdWidth-1:0] cmd,
                                   input int unsigned high_ticks,
                                   input int unsigned low_ticks, input logic noisy);
        int unsigned     wait_seen;
        int unsigned     charge_seen;
        logic [lvps_pkg::CmdWidth-1:0] c;
        logic            comp;
        wait_seen   = 0;
        charge_seen = 0;
        send_item(cmd, 1'b0);
        while (seq_phase != SEQ_IDLE)
        begin
            c    = noisy ? 2'($urandom) : lvps_pkg::CMD_TICK;
            comp = noisy ? 1'($urandom) : 1'b0;
            if (!noisy && seq_phase == SEQ_DISCHARGE)
            begin
                comp = (wait_seen < high_ticks);
                wait_seen++;
            end
            else if (!noisy && seq_phase == SEQ_CHARGE)
            begin
                comp = (charge_seen >= low_ticks);
                charge_seen++;
            end
            send_item(c, comp);
        end
    endtask

    task automatic test_reset_defaults();
        send_item(lvps_pkg::CMD_TICK, 1'b0);
        send_item(lvps_pkg::CMD_TICK, 1'b1);
        send_item(CMD_UNUSED, 1'b1);
        send_item(CMD_UNUSED, 1'b0);
        // default coil and half period, with a short recharge
        settle();
        put_reg(lvps_pkg::REG_RECHARGE, 24'd3);
        cfg_we <= 1'b0;
        valve_cfg.recharge_toggles = 16'd3;
        run_valve_cycle(lvps_pkg::CMD_OPEN, 3, 2, 1'b0);
    endtask

    task automatic test_open_close();
        set_config(24'd3, 24'd6, 16'd2, 16'd3);
        run_valve_cycle(lvps_pkg::CMD_OPEN, 2, 5, 1'b0);
        run_valve_cycle(lvps_pkg::CMD_CLOSE, 0, 0, 1'b0);
        // commands while busy must be ignored
        run_valve_cycle(lvps_pkg::CMD_CLOSE, 1, 3, 1'b1);
        send_item(CMD_UNUSED, 1'b1);
        run_valve_cycle(lvps_pkg::CMD_OPEN, 0, 1, 1'b1);
    endtask

    task automatic test_discharge_budget();
        set_config(24'd2, 24'd4, 16'd1, 16'd2);
        run_valve_cycle(lvps_pkg::CMD_OPEN, 4, 0, 1'b0);   // falls as the budget runs out
        run_valve_cycle(lvps_pkg::CMD_OPEN, 3, 0, 1'b0);   // falls one tick earlier
        run_valve_cycle(lvps_pkg::CMD_CLOSE, 9, 0, 1'b0);  // still high at timeout
        settle();
        set_config(24'd2, 24'd0, 16'd1, 16'd2);
        run_valve_cycle(lvps_pkg::CMD_CLOSE, 0, 0, 1'b0);
        run_valve_cycle(lvps_pkg::CMD_OPEN, 2, 2, 1'b0);
    endtask

    task automatic test_short_settings();
        set_config(24'd0, 24'd3, 16'd0, 16'd1);
        run_valve_cycle(lvps_pkg::CMD_OPEN, 1, 2, 1'b0);
        set_config(24'd1, 24'd1, 16'd1, 16'd1);
        run_valve_cycle(lvps_pkg::CMD_CLOSE, 1, 1, 1'b0);
        // odd recharge count leaves the boost switch high into the next run
        set_config(24'd2, 24'd2, 16'd3, 16'd5);
        run_valve_cycle(lvps_pkg::CMD_OPEN, 0, 4, 1'b0);
        run_valve_cycle(lvps_pkg::CMD_CLOSE, 1, 0, 1'b0);
    endtask

    task automatic test_extremes();
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        set_config(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
        send_item(lvps_pkg::CMD_TICK, 1'b1);
        send_item(CMD_UNUSED, 1'b0);
        set_config(24'd1, 24'hFFFFFF, 16'd1, 16'd1);
        run_valve_cycle(lvps_pkg::CMD_OPEN, 30, 0, 1'b0);
        set_config(24'd1, 24'd2, 16'd1, 16'd2);
        run_valve_cycle(lvps_pkg::CMD_CLOSE, 1, 1, 1'b0);
        tx_idling = 1'b1;
        rx_idling = 1'b1;
    endtask

    task automatic test_random_sequences();
        int unsigned start;
        int unsigned budget;
        start = ticks_sent;
        set_config(24'd2, 24'd4, 16'd2, 16'd2);
        while (ticks_sent - start < RANDOM_TICKS)
        begin
            tx_idling = ($urandom_range(0, 3) != 0);
            rx_idling = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0)
                set_config(24'($urandom_range(0, 4)), 24'($urandom_range(0, 8)),
                           16'($urandom_range(0, 3)), 16'($urandom_range(1, 4)));
            budget = 32'(valve_cfg.discharge_timeout_ticks);
            if ($urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    send_item($urandom_range(0, 1) ? lvps_pkg::CMD_TICK : CMD_UNUSED,
                              1'($urandom));
            end
            else
                run_valve_cycle($urandom_range(0, 1) ? lvps_pkg::CMD_OPEN : lvps_pkg::CMD_CLOSE,
                                $urandom_range(0, budget + 2), $urandom_range(0, 8),
                                $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                settle();
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_open_close();
        test_discharge_budget();
        test_short_settings();
        test_extremes();
        test_random_sequences();
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // result side: random stalls, every accepted item checked against the oldest prediction
    initial
    begin : result_sink
        int unsigned       stall;
        lvps_pkg::result_t want;
        lvps_pkg::result_t got;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = rx_idling ? $urandom_range(0, 9) : 0;
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got = m_tdata[6:0];
            if (expected_levels.size() == 0)
            begin
                $display("%0t: unexpected item expected none got %b", $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = expected_levels.pop_front();
                check_field("open_coil", want.open_coil, got.open_coil);
                check_field("close_coil", want.close_coil, got.close_coil);
                check_field("boost_switch", want.boost_switch, got.boost_switch);
                check_field("reference_on", want.reference_on, got.reference_on);
                check_field("busy_res", want.busy_res, got.busy_res);
                check_field("done_res", want.done_res, got.done_res);
                check_field("timeout_error", want.timeout_error, got.timeout_error);
                check_field("tdata padding", 1'b0, m_tdata[7]);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

FILE: sim.f
design/lvps_pkg.sv
design/lvps_core.sv
design/latching_valve_pulse_sequencer.sv
tb/tb_top.sv
